### design/osb3_pkg.sv
package osb3_pkg;

    // Multipliers of the 32-bit integer mix function.
    localparam logic [31:0] MIX_MUL1 = 32'h21f0aaad;
    localparam logic [31:0] MIX_MUL2 = 32'hd35a2d97;

    // The hash is divided by this to draw one of six permutations.
    localparam logic [31:0] PERM_DIVISOR  = 32'd715827882;
    localparam logic [2:0]  PERM_COUNT    = 3'd6;
    localparam logic [2:0]  FALLBACK_PERM = 3'd5;

    // Configuration register map (byte addresses).
    localparam logic [1:0]  ADDR_NUM_DIGITS  = 2'd0;
    localparam logic [3:0]  NUM_DIGITS_RESET = 4'd5;

    // Sequencer states: three multiply stages, then the draw is evaluated.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_EVAL,
        ST_DONE
    } t_state;

    // Control handed to every digit cell.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    // Image of digit d under permutation p of {0,1,2}.
    function automatic logic [1:0] perm_digit(input logic [2:0] p, input logic [1:0] d);
        logic [5:0] img;
        begin
            // Images of 2, 1, 0 packed from the top down.
            case (p)
                3'd0: img = {2'd2, 2'd1, 2'd0};
                3'd1: img = {2'd1, 2'd2, 2'd0};
                3'd2: img = {2'd2, 2'd0, 2'd1};
                3'd3: img = {2'd0, 2'd2, 2'd1};
                3'd4: img = {2'd1, 2'd0, 2'd2};
                default: img = {2'd0, 2'd1, 2'd2};
            endcase
            case (d)
                2'd0: perm_digit = img[1:0];
                2'd1: perm_digit = img[3:2];
                default: perm_digit = img[5:4];
            endcase
        end
    endfunction

endpackage

### design/osb3_cell.sv
module osb3_cell (
    input  logic                  i_clk,
    input  osb3_pkg::t_cell_ctrl  i_ctrl,
    input  logic [1:0]            i_load_digit,
    input  logic [1:0]            i_shift_digit,
    output logic [1:0]            o_digit
);

    logic [1:0] r_digit;

    // The cell takes its own input digit on load and its neighbor's digit on a shift.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_digit <= i_load_digit;
        end else if (i_ctrl.shift) begin
            r_digit <= i_shift_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

### design/osb3_hash.sv
module osb3_hash (
    input  logic        i_clk,
    input  logic [31:0] i_ctr,
    input  logic [31:0] i_key,
    output logic [2:0]  o_perm
);

    logic [31:0] r_m0;
    logic [31:0] r_m1;
    logic [31:0] r_m2;
    logic [31:0] w_x1;
    logic [31:0] w_x2;
    logic [31:0] w_hash;
    logic [2:0]  w_quot;

    // One multiplier per stage; the draw passes the registers r_m0, r_m1 and r_m2 before the sequencer reads it.
    assign w_x1 = r_m0 ^ (r_m0 >> 16);
    assign w_x2 = r_m1 ^ (r_m1 >> 15);

    always_ff @(posedge i_clk) begin
        r_m0 <= i_ctr * i_key;
        r_m1 <= w_x1 * osb3_pkg::MIX_MUL1;
        r_m2 <= w_x2 * osb3_pkg::MIX_MUL2;
    end

    assign w_hash = r_m2 ^ (r_m2 >> 15);

    // Quotient by the divisor: count the multiples of it that the hash reaches.
    always_comb begin
        w_quot = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if ({2'b00, w_hash} >= 34'(k) * {2'b00, osb3_pkg::PERM_DIVISOR}) begin
                w_quot = w_quot + 3'd1;
            end
        end
    end

    assign o_perm = w_quot;

endmodule

### design/owen_scramble_base3_digits_unit.sv
// Flow: IDLE takes the transaction, then each used digit runs draw attempts through the states
// MUL0, MUL1, MUL2 and EVAL (1 to 1+RETRY_LIMIT attempts per digit), and DONE posts the result,
// waiting while the output is held. One item is in work at a time.
// The draw loop runs through the three registered multiply stages of the hash.
// Reset clears the sequencer and the output valid and sets num_digits to 5.
module owen_scramble_base3_digits_unit #(
    parameter int MAX_DIGITS  = 10,
    parameter int RETRY_LIMIT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // digits_in[19:0], seed[50:20], zero pad
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digits_out[19:0], scrambled_value[35:20], zero pad
    output logic [1:0]  m_tuser    // bad_digit[0], retry_overflow[1]
);

    localparam int CW  = 2 * MAX_DIGITS;
    localparam int XW  = CW + 20;
    localparam int SHW = $clog2(XW);
    localparam int LW  = $clog2(MAX_DIGITS + 1);
    localparam int TW  = $clog2(RETRY_LIMIT + 1);

    osb3_pkg::t_state     r_state;
    osb3_pkg::t_state     n_state;
    osb3_pkg::t_cell_ctrl w_cell_ctrl;

    logic [3:0]    r_num_digits;
    logic [LW-1:0] r_level_cnt;
    logic [TW-1:0] r_try_cnt;
    logic [31:0]   r_ctr;
    logic [31:0]   r_node;
    logic [31:0]   r_key;
    logic [15:0]   r_value;
    logic          r_bad;
    logic          r_over;

    logic          r_out_valid;
    logic [19:0]   r_out_digits;
    logic [15:0]   r_out_value;
    logic          r_out_bad;
    logic          r_out_over;

    logic          w_accept;
    logic          w_out_load;
    logic          w_draw_ok;
    logic          w_last_try;
    logic          w_level_done;
    logic          w_last_level;
    logic [LW-1:0] w_nd;
    logic [XW-1:0] w_load_vec;
    logic [XW-1:0] w_out_vec;
    logic [CW-1:0] w_chain;
    logic [1:0]    w_cell [MAX_DIGITS];
    logic [1:0]    w_head;
    logic [1:0]    w_digit;
    logic [2:0]    w_draw;
    logic [2:0]    w_perm;
    logic [1:0]    w_new_digit;
    logic [31:0]   w_node_next;

    // Configuration register; writes land on the access cycle.
    assign pready = 1'b1;
    assign prdata = (paddr == osb3_pkg::ADDR_NUM_DIGITS) ? {28'd0, r_num_digits} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_digits <= osb3_pkg::NUM_DIGITS_RESET;
        end else if (psel && penable && pwrite && paddr == osb3_pkg::ADDR_NUM_DIGITS) begin
            r_num_digits <= pwdata[3:0];
        end
    end

    // Digit count clamped to the length of the cell chain.
    assign w_nd = (32'(r_num_digits) > MAX_DIGITS) ? LW'(MAX_DIGITS) : LW'(r_num_digits);

    // The most significant used digit is aligned to the head of the chain.
    assign w_load_vec = {{CW{1'b0}}, s_tdata[19:0]} << SHW'(2 * (MAX_DIGITS - 32'(w_nd)));

    // Chain of digit cells: the head feeds the walk, scrambled digits enter at the tail.
    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
        logic [1:0] w_shift_in;
        if (k == 0) begin : g_tail
            assign w_shift_in = w_new_digit;
        end else begin : g_link
            assign w_shift_in = w_cell[k-1];
        end
        osb3_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_cell_ctrl),
            .i_load_digit  (w_load_vec[2*k +: 2]),
            .i_shift_digit (w_shift_in),
            .o_digit       (w_cell[k])
        );
        assign w_chain[2*k +: 2] = w_cell[k];
    end

    assign w_head  = w_cell[MAX_DIGITS-1];
    assign w_digit = (w_head == 2'd3) ? 2'd2 : w_head;

    // Counter-based hash that draws the permutation for the current tree node.
    osb3_hash u_hash (
        .i_clk  (i_clk),
        .i_ctr  (r_ctr),
        .i_key  (r_key),
        .o_perm (w_draw)
    );

    assign w_draw_ok    = (w_draw < osb3_pkg::PERM_COUNT);
    assign w_last_try   = (r_try_cnt == TW'(RETRY_LIMIT));
    assign w_last_level = (r_level_cnt == LW'(1));
    assign w_perm       = w_draw_ok ? w_draw : osb3_pkg::FALLBACK_PERM;
    assign w_new_digit  = osb3_pkg::perm_digit(w_perm, w_digit);
    assign w_node_next  = r_node + {r_node[30:0], 1'b0} + 32'(w_digit) + 32'd1;

    // Sequencer outputs.
    always_comb begin
        s_tready         = 1'b0;
        w_cell_ctrl      = '0;
        w_level_done     = 1'b0;
        w_out_load       = 1'b0;
        case (r_state)
            osb3_pkg::ST_IDLE: begin
                s_tready         = 1'b1;
                w_cell_ctrl.load = s_tvalid;
            end
            osb3_pkg::ST_EVAL: begin
                w_level_done      = w_draw_ok || w_last_try;
                w_cell_ctrl.shift = w_level_done;
            end
            osb3_pkg::ST_DONE: begin
                w_out_load = !r_out_valid || m_tready;
            end
            default: begin
            end
        endcase
    end

    assign w_accept = s_tvalid && s_tready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            osb3_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = (w_nd == '0) ? osb3_pkg::ST_DONE : osb3_pkg::ST_MUL0;
                end
            end
            osb3_pkg::ST_MUL0: n_state = osb3_pkg::ST_MUL1;
            osb3_pkg::ST_MUL1: n_state = osb3_pkg::ST_MUL2;
            osb3_pkg::ST_MUL2: n_state = osb3_pkg::ST_EVAL;
            osb3_pkg::ST_EVAL: begin
                if (w_level_done && w_last_level) begin
                    n_state = osb3_pkg::ST_DONE;
                end else begin
                    n_state = osb3_pkg::ST_MUL0;
                end
            end
            osb3_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = osb3_pkg::ST_IDLE;
                end
            end
            default: n_state = osb3_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osb3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk state: tree node, hash counter, attempt and level counts, running value.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key       <= {s_tdata[50:20], 1'b1};
            r_node      <= 32'd0;
            r_ctr       <= 32'd1;
            r_value     <= 16'd0;
            r_bad       <= 1'b0;
            r_over      <= 1'b0;
            r_level_cnt <= w_nd;
            r_try_cnt   <= '0;
        end else if (r_state == osb3_pkg::ST_EVAL) begin
            if (w_level_done) begin
                r_node      <= w_node_next;
                r_ctr       <= w_node_next + 32'd1;
                r_value     <= r_value + {r_value[14:0], 1'b0} + 16'(w_new_digit);
                r_bad       <= r_bad || (w_head == 2'd3);
                r_over      <= r_over || !w_draw_ok;
                r_level_cnt <= r_level_cnt - LW'(1);
                r_try_cnt   <= '0;
            end else begin
                r_ctr     <= r_ctr + 32'd1;
                r_try_cnt <= r_try_cnt + TW'(1);
            end
        end
    end

    // Output register; the chain already holds zeros above the used digits.
    assign w_out_vec = {20'd0, w_chain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_digits <= w_out_vec[19:0];
            r_out_value  <= r_value;
            r_out_bad    <= r_bad;
            r_out_over   <= r_over;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_value, r_out_digits};
    assign m_tuser  = {r_out_over, r_out_bad};

endmodule
